// ----- hw/rtl/bft_pkg.sv -----
// Shared types and codes for the bidirectional flow table.
package bft_pkg;

    localparam int ADDR_W  = 32;
    localparam int PORT_W  = 16;
    localparam int PROTO_W = 3;
    localparam int STAT_W  = 2;

    // Command codes
    localparam logic CMD_ADD    = 1'b0;
    localparam logic CMD_LOOKUP = 1'b1;

    // Status codes
    localparam logic [STAT_W-1:0] ST_ADDED   = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STAT_W-1:0] ST_MATCH   = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOMATCH = 2'd3;

    // One stored connection
    typedef struct packed {
        logic [ADDR_W-1:0] sa;
        logic [ADDR_W-1:0] da;
        logic [PORT_W-1:0] sp;
        logic [PORT_W-1:0] dp;
    } flow_t;

    // Request word travelling along the cell chain
    typedef struct packed {
        logic               valid;
        logic               cmd;
        logic [PROTO_W-1:0] proto;
        logic               tcp;
        flow_t              flow;
    } req_t;

    // Result handed from a cell to the top level
    typedef struct packed {
        logic              done;
        logic [STAT_W-1:0] status;
    } cell_res_t;

endpackage

// ----- hw/rtl/bft_cell.sv -----
// One protocol cell: entry count, entry memory and scanning lookup engine.
module bft_cell
    import bft_pkg::*;
#(
    parameter int CELL_ID = 0,
    parameter int DEPTH   = 64
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  req_t      req_in,
    output req_t      req_out,
    output cell_res_t res
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_SCAN = 1'b1;

    flow_t             mem [DEPTH];

    req_t              fwd_reg, fwd_next;
    logic              state_reg, state_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     scan_reg, scan_next;
    logic              rd_valid_reg, rd_valid_next;
    logic              rd_last_reg, rd_last_next;
    flow_t             rd_data_reg;
    flow_t             query_reg, query_next;
    logic              done_reg, done_next;
    logic [STAT_W-1:0] status_reg, status_next;

    logic  mine;
    logic  wr_en;
    logic  issue;
    logic  hit;
    flow_t entry_new;

    // Claim the word when it names this cell's protocol
    assign mine = req_in.valid && (CELL_ID < (1 << PROTO_W))
                  && (req_in.proto == PROTO_W'(CELL_ID));

    // Ports are stored as zero without a TCP header
    always_comb
    begin
        entry_new    = req_in.flow;
        if (!req_in.tcp)
        begin
            entry_new.sp = '0;
            entry_new.dp = '0;
        end
    end

    assign wr_en = mine && (req_in.cmd == CMD_ADD) && (count_reg != CW'(DEPTH));
    assign issue = (state_reg == S_SCAN) && (scan_reg < count_reg);

    // Compare the fetched entry both ways round
    assign hit = rd_valid_reg &&
                 (((rd_data_reg.sa == query_reg.sa) && (rd_data_reg.da == query_reg.da) &&
                   (rd_data_reg.sp == query_reg.sp) && (rd_data_reg.dp == query_reg.dp)) ||
                  ((rd_data_reg.sa == query_reg.da) && (rd_data_reg.da == query_reg.sa) &&
                   (rd_data_reg.sp == query_reg.dp) && (rd_data_reg.dp == query_reg.sp)));

    // Next-state logic
    always_comb
    begin
        fwd_next       = req_in;
        fwd_next.valid = req_in.valid && !mine;
        state_next     = state_reg;
        count_next     = count_reg;
        scan_next      = scan_reg;
        rd_valid_next  = issue;
        rd_last_next   = issue && (scan_reg == count_reg - CW'(1));
        query_next     = query_reg;
        done_next      = 1'b0;
        status_next    = status_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (mine)
                begin
                    if (req_in.cmd == CMD_ADD)
                    begin
                        done_next = 1'b1;
                        if (wr_en)
                        begin
                            count_next  = count_reg + CW'(1);
                            status_next = ST_ADDED;
                        end
                        else
                        begin
                            status_next = ST_FULL;
                        end
                    end
                    else if (!req_in.tcp || (count_reg == '0))
                    begin
                        done_next   = 1'b1;
                        status_next = ST_NOMATCH;
                    end
                    else
                    begin
                        query_next = req_in.flow;
                        scan_next  = '0;
                        state_next = S_SCAN;
                    end
                end
            end
            S_SCAN:
            begin
                if (issue)
                begin
                    scan_next = scan_reg + CW'(1);
                end
                // Stop on a hit or after the last entry; drop any read in flight
                if (rd_valid_reg && (hit || rd_last_reg))
                begin
                    state_next    = S_IDLE;
                    done_next     = 1'b1;
                    status_next   = hit ? ST_MATCH : ST_NOMATCH;
                    rd_valid_next = 1'b0;
                    rd_last_next  = 1'b0;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fwd_reg      <= '0;
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            scan_reg     <= '0;
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= 1'b0;
            done_reg     <= 1'b0;
            status_reg   <= ST_ADDED;
        end
        else
        begin
            fwd_reg      <= fwd_next;
            state_reg    <= state_next;
            count_reg    <= count_next;
            scan_reg     <= scan_next;
            rd_valid_reg <= rd_valid_next;
            rd_last_reg  <= rd_last_next;
            done_reg     <= done_next;
            status_reg   <= status_next;
        end
    end

    // Hold the lookup key
    always_ff @(posedge clk)
    begin
        query_reg <= query_next;
    end

    // Entry memory: append at the count, read at the scan pointer
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[count_reg[AW-1:0]] <= entry_new;
        end
        if (issue)
        begin
            rd_data_reg <= mem[scan_reg[AW-1:0]];
        end
    end

    assign req_out    = fwd_reg;
    assign res.done   = done_reg;
    assign res.status = status_reg;

endmodule

// ----- hw/rtl/bidirectional_flow_table.sv -----
// Bidirectional IPv4 flow table: one connection table per protocol.
//
// Usage: drive the command word on command/protocol/src_addr/dst_addr/
// sport/dport/has_tcp and raise start; the word is taken at a rising
// edge where start is high and busy is low. Exactly one result follows:
// status is valid for the single cycle in which done is high.
// An add (command 0) appends the 4-tuple to its protocol's table, or reports
// the table full. A lookup (command 1) with has_tcp high reports whether any
// stored entry matches the packet forwards or with addresses and ports
// swapped; a lookup without has_tcp reports no match. The word walks a chain
// of NUM_PROTOCOLS cells, one cell per cycle, until the cell owning its
// protocol claims it; for a lookup, the owning cell then reads its entry
// memory one entry a cycle until a hit or the last stored entry. A word whose
// protocol has no cell passes the whole chain and reports full or no match.
// busy is high from the accepting edge until done, so one word is in flight
// at a time; a new word may be started in the cycle that done is high.
// Reset clears every entry count, so all tables read as empty. The receiver
// cannot stall: each result is taken in the cycle that it is shown.
module bidirectional_flow_table
    import bft_pkg::*;
#(
    parameter int NUM_PROTOCOLS        = 8,
    parameter int ENTRIES_PER_PROTOCOL = 64
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               command,
    input  logic [PROTO_W-1:0] protocol,
    input  logic [ADDR_W-1:0]  src_addr,
    input  logic [ADDR_W-1:0]  dst_addr,
    input  logic [PORT_W-1:0]  sport,
    input  logic [PORT_W-1:0]  dport,
    input  logic               has_tcp,
    output logic               done,
    output logic [STAT_W-1:0]  status
);

    req_t              head_reg;
    req_t              chain [NUM_PROTOCOLS+1];
    cell_res_t         res [NUM_PROTOCOLS];
    logic [NUM_PROTOCOLS:0] done_vec;

    logic              busy_reg;
    logic              done_reg;
    logic [STAT_W-1:0] status_reg;

    logic              accept;
    logic              done_next;
    logic [STAT_W-1:0] status_next;

    assign accept = start && !busy_reg;

    // Launch the command word into the chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
        end
        else
        begin
            head_reg.valid   <= accept;
            head_reg.cmd     <= command;
            head_reg.proto   <= protocol;
            head_reg.tcp     <= has_tcp;
            head_reg.flow.sa <= src_addr;
            head_reg.flow.da <= dst_addr;
            head_reg.flow.sp <= sport;
            head_reg.flow.dp <= dport;
        end
    end

    assign chain[0] = head_reg;

    // Row of protocol cells
    for (genvar g = 0; g < NUM_PROTOCOLS; g++)
    begin : g_cell
        bft_cell #(
            .CELL_ID (g),
            .DEPTH   (ENTRIES_PER_PROTOCOL)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .req_in  (chain[g]),
            .req_out (chain[g+1]),
            .res     (res[g])
        );
        assign done_vec[g] = res[g].done;
    end

    assign done_vec[NUM_PROTOCOLS] = chain[NUM_PROTOCOLS].valid;

    // Gather the result; an unclaimed word is full or no match
    always_comb
    begin
        done_next   = chain[NUM_PROTOCOLS].valid;
        status_next = (chain[NUM_PROTOCOLS].cmd == CMD_ADD) ? ST_FULL : ST_NOMATCH;
        for (int i = 0; i < NUM_PROTOCOLS; i++)
        begin
            if (res[i].done)
            begin
                done_next   = 1'b1;
                status_next = res[i].status;
            end
        end
    end

    // Result register and busy flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg   <= 1'b0;
            done_reg   <= 1'b0;
            status_reg <= ST_ADDED;
        end
        else
        begin
            done_reg   <= done_next;
            status_reg <= status_next;
            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (done_next)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign status = status_reg;

    // At most one place in the chain finishes a word per cycle
    a_one_finisher: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(done_vec))
        else $error("more than one cell finished in the same cycle");

    // An accepted word keeps the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy)
        else $error("busy not raised after accept");

    // busy drops only together with a result
    a_busy_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> done)
        else $error("busy dropped without a result");

    // No result while a word is still in flight
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // One result per word: never two in consecutive cycles
    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result repeated");

endmodule
